// ===== design/msba_pkg.sv =====
// shared types, widths and status codes for the multi-slot bump allocator
package msba_pkg;

   localparam int SIZE_W     = 36;
   localparam int ALIGN_W    = 6;
   localparam int MASK_W     = 32;
   localparam int SLOT_IDX_W = 5;
   localparam int STATUS_W   = 2;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_TOO_LARGE = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;

endpackage

// ===== design/msba_fill_mem.sv =====
// fill level store, one write port and one registered read port
module msba_fill_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 36,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/msba_fit_unit.sv =====
// shared align-and-fit unit: rounds a fill up to the alignment and checks headroom
module msba_fit_unit #(
   parameter int OB = 36,
   parameter int CW = 36
) (
   input  logic [OB-1:0]                  base,
   input  logic [msba_pkg::ALIGN_W-1:0]   align_log2,
   input  logic [CW-1:0]                  headroom,
   output logic [OB:0]                    offset,
   output logic                           fits
);

   logic [OB-1:0] low_mask;
   logic [CW:0]   offset_ext;

   // shifts of OB or more clear every bit, so the mask saturates to all ones
   assign low_mask = ~({OB{1'b1}} << align_log2);

   always_comb begin
      if ((base & low_mask) == '0) begin
         offset = {1'b0, base};
      end else begin
         offset = {1'b0, base | low_mask} + (OB+1)'(1);
      end
   end

   assign offset_ext = (CW+1)'(offset);
   assign fits       = (offset_ext <= {1'b0, headroom});

endmodule

// ===== design/multi_slot_bump_allocator_unit.sv =====
// top level: multi-slot bump allocator with a slot-serial scan sequencer
// steps: setup, a serial scan up to the chosen slot, commit on a hit, then output load
//   an oversized request goes from setup straight to output load; a full one skips commit
// output load waits while the prior response is unaccepted; no request is taken before it
// a new request is taken while the previous response still waits on rsp_ready
// reset: synchronous active high, clears arena size, open flags and control, not the fill store
module multi_slot_bump_allocator_unit #(
   parameter int NUM_SLOTS   = 32,
   parameter int OFFSET_BITS = 36
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [msba_pkg::SIZE_W-1:0]         req_request_bytes,
   input  logic [msba_pkg::ALIGN_W-1:0]        req_align_log2,
   input  logic [msba_pkg::MASK_W-1:0]         req_slot_mask,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [msba_pkg::STATUS_W-1:0]       rsp_status,
   output logic [msba_pkg::SLOT_IDX_W-1:0]     rsp_slot_index,
   output logic [msba_pkg::SIZE_W-1:0]         rsp_offset,
   output logic                                rsp_slot_opened,
   // arena size register
   input  logic                                csr_wr_en,
   input  logic [msba_pkg::SIZE_W-1:0]         csr_wr_data
);

   // slot index width and the compare width covering both arena and fill
   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int OB = OFFSET_BITS;
   localparam int CW = (OB > msba_pkg::SIZE_W) ? OB : msba_pkg::SIZE_W;
   localparam logic [CW-1:0] OFF_MAX   = ~({CW{1'b1}} << OB);
   localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREP   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [msba_pkg::SIZE_W-1:0]   arena_ff, arena_in;
   logic [NUM_SLOTS-1:0]          open_ff, open_in;

   // captured request
   logic [msba_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [msba_pkg::ALIGN_W-1:0]  align_ff, align_in;
   logic [msba_pkg::MASK_W-1:0]   mask_ff, mask_in;

   // per-request derived values
   logic [CW-1:0]                 headroom_ff, headroom_in;
   logic                          size_fits_ff, size_fits_in;
   logic [SW-1:0]                 scan_idx_ff, scan_idx_in;

   // result staging
   msba_pkg::status_type          res_status_ff, res_status_in;
   logic [OB-1:0]                 res_off_ff, res_off_in;
   logic                          res_opened_ff, res_opened_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   msba_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [msba_pkg::SLOT_IDX_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [msba_pkg::SIZE_W-1:0]   rsp_off_ff, rsp_off_in;
   logic                          rsp_opened_ff, rsp_opened_in;

   // datapath wires
   logic [CW-1:0]                 arena_ext;
   logic [CW-1:0]                 limit;
   logic [CW-1:0]                 size_ext;
   logic                          too_large;
   logic [SW-1:0]                 rd_addr;
   logic [OB-1:0]                 rd_fill;
   logic [OB-1:0]                 scan_base;
   logic [OB:0]                   fit_off;
   logic                          fit_ok;
   logic                          slot_hit;
   logic                          mem_wr_en;
   logic [CW:0]                   fill_end;
   logic                          out_free;

   // limit is the lesser of arena size and the largest storable fill
   assign arena_ext = CW'(arena_ff);
   assign size_ext  = CW'(size_ff);
   assign limit     = (arena_ext < OFF_MAX) ? arena_ext : OFF_MAX;
   assign too_large = (size_ff > arena_ff);

   // read slot 0 during setup, then run one slot ahead of the scan
   assign rd_addr = (state_ff == S_SCAN) ? (scan_idx_ff + SW'(1)) : '0;

   msba_fill_mem #(
      .DEPTH (NUM_SLOTS),
      .WIDTH (OB),
      .AW    (SW)
   ) u_fill_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (scan_idx_ff),
      .wr_data (fill_end[OB-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_fill)
   );

   // unopened slot starts empty; its stored fill is never looked at
   assign scan_base = open_ff[scan_idx_ff] ? rd_fill : '0;

   msba_fit_unit #(
      .OB (OB),
      .CW (CW)
   ) u_fit_unit (
      .base       (scan_base),
      .align_log2 (align_ff),
      .headroom   (headroom_ff),
      .offset     (fit_off),
      .fits       (fit_ok)
   );

   // mask bits at or above NUM_SLOTS are never visited
   assign slot_hit  = mask_ff[scan_idx_ff] && size_fits_ff && fit_ok;
   assign fill_end  = (CW+1)'(res_off_ff) + (CW+1)'(size_ff);
   assign mem_wr_en = (state_ff == S_COMMIT);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      arena_in      = arena_ff;
      open_in       = open_ff;
      size_in       = size_ff;
      align_in      = align_ff;
      mask_in       = mask_ff;
      headroom_in   = headroom_ff;
      size_fits_in  = size_fits_ff;
      scan_idx_in   = scan_idx_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      res_opened_in = res_opened_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_opened_in = rsp_opened_ff;

      // arena size register write
      if (csr_wr_en) begin
         arena_in = csr_wr_data;
      end

      // response handed off
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               size_in  = req_request_bytes;
               align_in = req_align_log2;
               mask_in  = req_slot_mask;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            // room test becomes offset <= limit - size
            size_fits_in = (size_ext <= limit);
            headroom_in  = limit - size_ext;
            scan_idx_in  = '0;
            if (too_large) begin
               res_status_in = msba_pkg::STATUS_TOO_LARGE;
               res_off_in    = '0;
               res_opened_in = 1'b0;
               state_in      = S_OUT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (slot_hit) begin
               res_status_in = msba_pkg::STATUS_OK;
               res_off_in    = fit_off[OB-1:0];
               res_opened_in = !open_ff[scan_idx_ff];
               state_in      = S_COMMIT;
            end else if (scan_idx_ff == LAST_SLOT) begin
               res_status_in = msba_pkg::STATUS_FULL;
               res_off_in    = '0;
               res_opened_in = 1'b0;
               scan_idx_in   = '0;
               state_in      = S_OUT;
            end else begin
               scan_idx_in = scan_idx_ff + SW'(1);
            end
         end
         S_COMMIT: begin
            // fill store written by the memory port in this state
            open_in[scan_idx_ff] = 1'b1;
            state_in             = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = (res_status_ff == msba_pkg::STATUS_OK) ?
                               msba_pkg::SLOT_IDX_W'(scan_idx_ff) : '0;
               rsp_off_in    = msba_pkg::SIZE_W'(res_off_ff);
               rsp_opened_in = res_opened_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         arena_ff     <= '0;
         open_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         arena_ff     <= arena_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_idx_ff  <= scan_idx_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      align_ff      <= align_in;
      mask_ff       <= mask_in;
      headroom_ff   <= headroom_in;
      size_fits_ff  <= size_fits_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      res_opened_ff <= res_opened_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_opened_ff <= rsp_opened_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_offset      = rsp_off_ff;
   assign rsp_slot_opened = rsp_opened_ff;

`ifndef SYNTHESIS
   // an accepted transaction always goes to setup next
   a_accept_to_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_PREP))
      else $error("accepted request did not enter setup");

   // a successful response names a slot that is now open
   a_ok_slot_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == msba_pkg::STATUS_OK)) |->
      open_ff[rsp_slot_ff[SW-1:0]])
      else $error("success reported on a slot that is not open");

   // a new response is only produced by the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("response raised outside output state");

   // fill store is written only while scanning has stopped on a hit
   a_commit_ok: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (res_status_ff == msba_pkg::STATUS_OK))
      else $error("fill written without a successful allocation");
`endif

endmodule
